>>> rtl/core/rgbfx_pkg.sv
package rgbfx_pkg;

   // Field and register widths
   localparam int PHASE_W  = 12;
   localparam int PERIOD_W = 16;
   localparam int RGB_W    = 24;
   localparam int MODE_W   = 3;
   localparam int REG_W    = 3;

   // Refresh interval default in milliseconds
   localparam int TICK_MS_DEF = 20;

   // Effect table sizes
   localparam int BREATH_STEPS = 64;
   localparam int BREATH_W     = $clog2(BREATH_STEPS);
   localparam int HUE_STEPS    = 360;
   localparam int HUE_HALF     = HUE_STEPS / 2;
   localparam int HUE_W        = $clog2(HUE_STEPS);

   // Per-mode minimum periods in milliseconds
   localparam logic [PERIOD_W-1:0] PERIOD_MIN_BREATH  = 16'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN_RAINBOW = 16'd2000;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN_BLINK   = 16'd200;

   // Effect modes
   localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BREATH  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BLINK   = 3'd4;

   // Register indexes
   localparam logic [REG_W-1:0] REG_MODE   = 3'd0;
   localparam logic [REG_W-1:0] REG_LEFT   = 3'd1;
   localparam logic [REG_W-1:0] REG_RIGHT  = 3'd2;
   localparam logic [REG_W-1:0] REG_PERIOD = 3'd3;
   localparam logic [REG_W-1:0] REG_MIRROR = 3'd4;

   // Register reset values
   localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_RAINBOW;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd12000;
   localparam logic                MIRROR_RESET = 1'b1;

   // Sine-shaped brightness ratios, one breathing cycle
   localparam logic [7:0] BREATH_ROM [0:BREATH_STEPS-1] = '{
      8'd128, 8'd140, 8'd152, 8'd164, 8'd176, 8'd187, 8'd198, 8'd208,
      8'd217, 8'd225, 8'd232, 8'd238, 8'd243, 8'd247, 8'd250, 8'd251,
      8'd252, 8'd251, 8'd250, 8'd247, 8'd243, 8'd238, 8'd232, 8'd225,
      8'd217, 8'd208, 8'd198, 8'd187, 8'd176, 8'd164, 8'd152, 8'd140,
      8'd128, 8'd115, 8'd103, 8'd91,  8'd79,  8'd68,  8'd57,  8'd47,
      8'd38,  8'd30,  8'd23,  8'd17,  8'd12,  8'd8,   8'd5,   8'd4,
      8'd3,   8'd4,   8'd5,   8'd8,   8'd12,  8'd17,  8'd23,  8'd30,
      8'd38,  8'd47,  8'd57,  8'd68,  8'd79,  8'd91,  8'd103, 8'd115
   };

   // Hue wheel in GRB layout, one entry per degree
   localparam logic [RGB_W-1:0] HUE_ROM [0:HUE_STEPS-1] = '{
      24'h00FF00, 24'h04FF00, 24'h08FF00, 24'h0DFF00, 24'h11FF00,
      24'h15FF00, 24'h19FF00, 24'h1EFF00, 24'h22FF00, 24'h26FF00,
      24'h2AFF00, 24'h2FFF00, 24'h33FF00, 24'h37FF00, 24'h3CFF00,
      24'h40FF00, 24'h44FF00, 24'h48FF00, 24'h4DFF00, 24'h51FF00,
      24'h55FF00, 24'h59FF00, 24'h5EFF00, 24'h62FF00, 24'h66FF00,
      24'h6AFF00, 24'h6EFF00, 24'h73FF00, 24'h77FF00, 24'h7BFF00,
      24'h80FF00, 24'h84FF00, 24'h88FF00, 24'h8CFF00, 24'h90FF00,
      24'h95FF00, 24'h99FF00, 24'h9DFF00, 24'hA2FF00, 24'hA6FF00,
      24'hAAFF00, 24'hAEFF00, 24'hB2FF00, 24'hB7FF00, 24'hBBFF00,
      24'hBFFF00, 24'hC3FF00, 24'hC8FF00, 24'hCCFF00, 24'hD0FF00,
      24'hD4FF00, 24'hD9FF00, 24'hDDFF00, 24'hE1FF00, 24'hE5FF00,
      24'hEAFF00, 24'hEEFF00, 24'hF2FF00, 24'hF7FF00, 24'hFBFF00,
      24'hFFFF00, 24'hFFFB00, 24'hFFF700, 24'hFFF200, 24'hFFEE00,
      24'hFFEA00, 24'hFFE600, 24'hFFE100, 24'hFFDD00, 24'hFFD900,
      24'hFFD400, 24'hFFD000, 24'hFFCC00, 24'hFFC800, 24'hFFC300,
      24'hFFBF00, 24'hFFBB00, 24'hFFB700, 24'hFFB200, 24'hFFAE00,
      24'hFFAA00, 24'hFFA600, 24'hFFA200, 24'hFF9D00, 24'hFF9900,
      24'hFF9500, 24'hFF9000, 24'hFF8C00, 24'hFF8800, 24'hFF8400,
      24'hFF8000, 24'hFF7B00, 24'hFF7700, 24'hFF7300, 24'hFF6E00,
      24'hFF6A00, 24'hFF6600, 24'hFF6200, 24'hFF5E00, 24'hFF5900,
      24'hFF5500, 24'hFF5100, 24'hFF4D00, 24'hFF4800, 24'hFF4400,
      24'hFF4000, 24'hFF3C00, 24'hFF3700, 24'hFF3300, 24'hFF2F00,
      24'hFF2A00, 24'hFF2600, 24'hFF2200, 24'hFF1E00, 24'hFF1A00,
      24'hFF1500, 24'hFF1100, 24'hFF0D00, 24'hFF0800, 24'hFF0400,
      24'hFF0000, 24'hFF0004, 24'hFF0008, 24'hFF000D, 24'hFF0011,
      24'hFF0015, 24'hFF0019, 24'hFF001E, 24'hFF0022, 24'hFF0026,
      24'hFF002A, 24'hFF002F, 24'hFF0033, 24'hFF0037, 24'hFF003C,
      24'hFF0040, 24'hFF0044, 24'hFF0048, 24'hFF004D, 24'hFF0051,
      24'hFF0055, 24'hFF0059, 24'hFF005E, 24'hFF0062, 24'hFF0066,
      24'hFF006A, 24'hFF006F, 24'hFF0073, 24'hFF0077, 24'hFF007B,
      24'hFF0080, 24'hFF0084, 24'hFF0088, 24'hFF008C, 24'hFF0090,
      24'hFF0095, 24'hFF0099, 24'hFF009D, 24'hFF00A2, 24'hFF00A6,
      24'hFF00AA, 24'hFF00AE, 24'hFF00B3, 24'hFF00B7, 24'hFF00BB,
      24'hFF00BF, 24'hFF00C3, 24'hFF00C8, 24'hFF00CC, 24'hFF00D0,
      24'hFF00D4, 24'hFF00D9, 24'hFF00DD, 24'hFF00E1, 24'hFF00E5,
      24'hFF00EA, 24'hFF00EE, 24'hFF00F2, 24'hFF00F7, 24'hFF00FB,
      24'hFF00FF, 24'hFB00FF, 24'hF700FF, 24'hF200FF, 24'hEE00FF,
      24'hEA00FF, 24'hE500FF, 24'hE100FF, 24'hDD00FF, 24'hD900FF,
      24'hD400FF, 24'hD000FF, 24'hCC00FF, 24'hC800FF, 24'hC300FF,
      24'hBF00FF, 24'hBB00FF, 24'hB700FF, 24'hB200FF, 24'hAE00FF,
      24'hAA00FF, 24'hA600FF, 24'hA200FF, 24'h9D00FF, 24'h9900FF,
      24'h9500FF, 24'h9100FF, 24'h8C00FF, 24'h8800FF, 24'h8400FF,
      24'h8000FF, 24'h7B00FF, 24'h7700FF, 24'h7300FF, 24'h6F00FF,
      24'h6A00FF, 24'h6600FF, 24'h6200FF, 24'h5E00FF, 24'h5900FF,
      24'h5500FF, 24'h5100FF, 24'h4C00FF, 24'h4800FF, 24'h4400FF,
      24'h4000FF, 24'h3C00FF, 24'h3700FF, 24'h3300FF, 24'h2F00FF,
      24'h2B00FF, 24'h2600FF, 24'h2200FF, 24'h1E00FF, 24'h1900FF,
      24'h1500FF, 24'h1100FF, 24'h0D00FF, 24'h0800FF, 24'h0400FF,
      24'h0000FF, 24'h0004FF, 24'h0008FF, 24'h000DFF, 24'h0011FF,
      24'h0015FF, 24'h0019FF, 24'h001EFF, 24'h0022FF, 24'h0026FF,
      24'h002AFF, 24'h002FFF, 24'h0033FF, 24'h0037FF, 24'h003CFF,
      24'h0040FF, 24'h0044FF, 24'h0048FF, 24'h004CFF, 24'h0051FF,
      24'h0055FF, 24'h0059FF, 24'h005DFF, 24'h0062FF, 24'h0066FF,
      24'h006AFF, 24'h006FFF, 24'h0073FF, 24'h0077FF, 24'h007BFF,
      24'h0080FF, 24'h0084FF, 24'h0088FF, 24'h008CFF, 24'h0090FF,
      24'h0095FF, 24'h0099FF, 24'h009DFF, 24'h00A2FF, 24'h00A6FF,
      24'h00AAFF, 24'h00AEFF, 24'h00B3FF, 24'h00B7FF, 24'h00BBFF,
      24'h00BFFF, 24'h00C3FF, 24'h00C8FF, 24'h00CCFF, 24'h00D0FF,
      24'h00D5FF, 24'h00D9FF, 24'h00DDFF, 24'h00E1FF, 24'h00E6FF,
      24'h00EAFF, 24'h00EEFF, 24'h00F2FF, 24'h00F7FF, 24'h00FBFF,
      24'h00FFFF, 24'h00FFFB, 24'h00FFF7, 24'h00FFF2, 24'h00FFEE,
      24'h00FFEA, 24'h00FFE6, 24'h00FFE1, 24'h00FFDD, 24'h00FFD9,
      24'h00FFD4, 24'h00FFD0, 24'h00FFCC, 24'h00FFC8, 24'h00FFC3,
      24'h00FFBF, 24'h00FFBB, 24'h00FFB7, 24'h00FFB3, 24'h00FFAE,
      24'h00FFAA, 24'h00FFA6, 24'h00FFA1, 24'h00FF9D, 24'h00FF99,
      24'h00FF95, 24'h00FF90, 24'h00FF8C, 24'h00FF88, 24'h00FF84,
      24'h00FF80, 24'h00FF7B, 24'h00FF77, 24'h00FF73, 24'h00FF6F,
      24'h00FF6A, 24'h00FF66, 24'h00FF62, 24'h00FF5E, 24'h00FF59,
      24'h00FF55, 24'h00FF51, 24'h00FF4D, 24'h00FF48, 24'h00FF44,
      24'h00FF40, 24'h00FF3C, 24'h00FF37, 24'h00FF33, 24'h00FF2F,
      24'h00FF2B, 24'h00FF26, 24'h00FF22, 24'h00FF1E, 24'h00FF1A,
      24'h00FF15, 24'h00FF11, 24'h00FF0D, 24'h00FF08, 24'h00FF04
   };

endpackage

>>> rtl/core/rgbfx_div.sv
module rgbfx_div #(
   parameter int N_W = 25,
   parameter int D_W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient,
   output logic [D_W-1:0] remainder
);

   localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   dvs_ff, dvs_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;
   logic             fits;

   // One restoring step per cycle: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial     = {rem_ff, quo_ff[N_W-1]};
      diff      = trial - {1'b0, dvs_ff};
      fits      = (trial >= {1'b0, dvs_ff});
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         quo_in    = dividend;
         rem_in    = '0;
         dvs_in    = divisor;
      end else if (active_ff) begin
         rem_in = fits ? diff[D_W-1:0] : trial[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/core/rgb_led_effect_generator_core.sv
// Channel  | Direction | Payload
// ---------+-----------+-------------------------------------------------------
// req_     | in        | tdata[0] tick
// rsp_     | out       | tdata: left red, green, blue, right red, green, blue
// csr_     | in/out    | APB registers: mode, left, right, period, mirror
//
// A tick takes longest in breathing mode: the shared bit-serial divider runs the
// phase wrap and the table position divisions, then three byte-scaling passes
// follow. Rainbow, blink and solid take fewer cycles, as do ticks that give
// no result.
// req_tready is high only while the sequencer is idle; a finished result waits
// in the output register, so a new tick is taken while rsp_ is stalled.
// Synchronous reset restores the register defaults and clears the phase.
module rgb_led_effect_generator_core #(
   parameter int TICK_MS = rgbfx_pkg::TICK_MS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // [7:0] left_red, [15:8] left_green,
                                     // [23:16] left_blue, [31:24] right_red,
                                     // [39:32] right_green, [47:40] right_blue
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PH_W     = rgbfx_pkg::PHASE_W;
   localparam int PER_W    = rgbfx_pkg::PERIOD_W;
   localparam int RGB_W    = rgbfx_pkg::RGB_W;
   localparam int HUE_W    = rgbfx_pkg::HUE_W;
   localparam int K_BREATH = rgbfx_pkg::BREATH_STEPS * TICK_MS;
   localparam int K_HUE    = rgbfx_pkg::HUE_STEPS * TICK_MS;
   localparam int K_W      = $clog2(K_HUE + 1);
   localparam int PROD_W   = PH_W + K_W;
   // Reciprocal of the tick length, exact for any 16-bit period
   localparam int RCP_SH   = PER_W + $clog2(TICK_MS);
   localparam int RCP      = ((1 << RCP_SH) + TICK_MS - 1) / TICK_MS;
   localparam int RCP_W    = PER_W + 2;
   localparam int MP_W     = RCP_SH + PER_W;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MOD   = 4'd1;
   localparam logic [3:0] S_PHASE = 4'd2;
   localparam logic [3:0] S_DISP  = 4'd3;
   localparam logic [3:0] S_QGO   = 4'd4;
   localparam logic [3:0] S_QDIV  = 4'd5;
   localparam logic [3:0] S_SCMUL = 4'd6;
   localparam logic [3:0] S_SCALE = 4'd7;
   localparam logic [3:0] S_HUEL  = 4'd8;
   localparam logic [3:0] S_HUER  = 4'd9;
   localparam logic [3:0] S_BLINK = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   logic [3:0]                      state_ff, state_in;
   logic [rgbfx_pkg::MODE_W-1:0]    mode_ff, mode_in;
   logic [RGB_W-1:0]                left_rgb_ff, left_rgb_in;
   logic [RGB_W-1:0]                right_rgb_ff, right_rgb_in;
   logic [PER_W-1:0]                period_reg_ff, period_reg_in;
   logic                            mirror_ff, mirror_in;
   logic [PH_W-1:0]                 phase_ff, phase_in;
   logic [PER_W-1:0]                period_ff, period_in;
   logic [PER_W-1:0]                modulus_ff, modulus_in;
   logic [7:0]                      ratio_ff, ratio_in;
   logic [HUE_W-1:0]                hue_ff, hue_in;
   logic [1:0]                      sc_ff, sc_in;
   logic [RGB_W-1:0]                left_grb_ff, left_grb_in;
   logic [RGB_W-1:0]                right_grb_ff, right_grb_in;
   logic [PROD_W-1:0]               prod_ff, prod_in;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [47:0]                     rsp_tdata_ff, rsp_tdata_in;

   logic                            cfg_wr;
   logic [PER_W-1:0]                period_eff;
   logic [PER_W-1:0]                half;
   logic [MP_W-1:0]                 mod_prod;
   logic [PER_W-1:0]                mod_quo;
   logic [PH_W-1:0]                 mul_a;
   logic [K_W-1:0]                  mul_b;
   logic                            div_start;
   logic [PROD_W-1:0]               div_dividend;
   logic [PER_W-1:0]                div_divisor;
   logic                            div_done;
   logic [PROD_W-1:0]               div_quo;
   logic [PER_W-1:0]                div_rem;
   logic [PROD_W-1:0]               hue_q;
   logic [HUE_W:0]                  hue_sum;
   logic [HUE_W-1:0]                hue_opp;
   logic [7:0]                      sc_byte;
   logic [16:0]                     sc_sum;
   logic [7:0]                      sc_res;
   logic                            load_out;

   // Shared restoring divider
   rgbfx_div #(
      .N_W (PROD_W),
      .D_W (PER_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign half       = modulus_ff >> 1;

   // Ticks per period from the held period
   assign mod_prod = MP_W'(period_ff) * MP_W'(RCP_W'(RCP));
   assign mod_quo  = mod_prod[RCP_SH +: PER_W];

   // Raise the period to the mode's minimum
   always_comb begin
      period_eff = period_reg_ff;
      case (mode_ff)
         rgbfx_pkg::MODE_BREATH: begin
            if (period_reg_ff < rgbfx_pkg::PERIOD_MIN_BREATH) begin
               period_eff = rgbfx_pkg::PERIOD_MIN_BREATH;
            end
         end
         rgbfx_pkg::MODE_RAINBOW: begin
            if (period_reg_ff < rgbfx_pkg::PERIOD_MIN_RAINBOW) begin
               period_eff = rgbfx_pkg::PERIOD_MIN_RAINBOW;
            end
         end
         rgbfx_pkg::MODE_BLINK: begin
            if (period_reg_ff < rgbfx_pkg::PERIOD_MIN_BLINK) begin
               period_eff = rgbfx_pkg::PERIOD_MIN_BLINK;
            end
         end
         default: ;
      endcase
   end

   // Hue wrap, opposite hue and byte scaling helpers
   always_comb begin
      hue_q   = (div_quo >= PROD_W'(rgbfx_pkg::HUE_STEPS))
                ? div_quo - PROD_W'(rgbfx_pkg::HUE_STEPS) : div_quo;
      hue_sum = {1'b0, hue_ff} + (HUE_W + 1)'(rgbfx_pkg::HUE_HALF);
      hue_opp = (hue_sum >= (HUE_W + 1)'(rgbfx_pkg::HUE_STEPS))
                ? hue_sum[HUE_W-1:0] - HUE_W'(rgbfx_pkg::HUE_STEPS) : hue_sum[HUE_W-1:0];
      case (sc_ff)
         2'd0:    sc_byte = left_rgb_ff[7:0];
         2'd1:    sc_byte = left_rgb_ff[15:8];
         default: sc_byte = left_rgb_ff[23:16];
      endcase
      // Exact divide by 255 for a 16-bit product
      sc_sum = {1'b0, prod_ff[15:0]} + 17'(prod_ff[15:8]) + 17'd1;
      sc_res = sc_sum[15:8];
   end

   // Sequencer and register file
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      left_rgb_in   = left_rgb_ff;
      right_rgb_in  = right_rgb_ff;
      period_reg_in = period_reg_ff;
      mirror_in     = mirror_ff;
      phase_in      = phase_ff;
      period_in     = period_ff;
      modulus_in    = modulus_ff;
      ratio_in      = ratio_ff;
      hue_in        = hue_ff;
      sc_in         = sc_ff;
      left_grb_in   = left_grb_ff;
      right_grb_in  = right_grb_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = '0;
      mul_a         = phase_ff;
      mul_b         = K_W'(K_BREATH);
      load_out      = 1'b0;

      // Register writes; any listed register clears the phase
      if (cfg_wr) begin
         case (csr_paddr[4:2])
            rgbfx_pkg::REG_MODE: begin
               mode_in  = csr_pwdata[rgbfx_pkg::MODE_W-1:0];
               phase_in = '0;
            end
            rgbfx_pkg::REG_LEFT: begin
               left_rgb_in = csr_pwdata[RGB_W-1:0];
               phase_in    = '0;
            end
            rgbfx_pkg::REG_RIGHT: begin
               right_rgb_in = csr_pwdata[RGB_W-1:0];
               phase_in     = '0;
            end
            rgbfx_pkg::REG_PERIOD: begin
               period_reg_in = csr_pwdata[PER_W-1:0];
               phase_in      = '0;
            end
            rgbfx_pkg::REG_MIRROR: begin
               mirror_in = csr_pwdata[0];
               phase_in  = '0;
            end
            default: ;
         endcase
      end

      case (state_ff)
         // Take a tick and hold its effective period
         S_IDLE: begin
            if (req_tvalid && req_tdata[0]) begin
               period_in = period_eff;
               state_in  = S_MOD;
            end
         end
         // Advance the phase modulo the tick count of one period
         S_MOD: begin
            modulus_in = mod_quo;
            if (mod_quo == '0) begin
               phase_in = '0;
               state_in = S_DISP;
            end else begin
               div_start    = 1'b1;
               div_dividend = PROD_W'({1'b0, phase_ff} + (PH_W + 1)'(1));
               div_divisor  = mod_quo;
               state_in     = S_PHASE;
            end
         end
         S_PHASE: begin
            if (div_done) begin
               phase_in = div_rem[PH_W-1:0];
               state_in = S_DISP;
            end
         end
         // Branch on the effect; the phase product is captured here
         S_DISP: begin
            if (mode_ff == rgbfx_pkg::MODE_RAINBOW) begin
               mul_b = K_W'(K_HUE);
            end
            case (mode_ff)
               rgbfx_pkg::MODE_SOLID: begin
                  left_grb_in  = left_rgb_ff;
                  right_grb_in = right_rgb_ff;
                  state_in     = S_OUT;
               end
               rgbfx_pkg::MODE_BREATH, rgbfx_pkg::MODE_RAINBOW: begin
                  state_in = S_QGO;
               end
               rgbfx_pkg::MODE_BLINK: begin
                  if (half == '0) begin
                     left_grb_in  = left_rgb_ff;
                     right_grb_in = mirror_ff ? left_rgb_ff : '0;
                     state_in     = S_OUT;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = PROD_W'(phase_ff);
                     div_divisor  = half;
                     state_in     = S_BLINK;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         // Table position: phase * steps * tick / period
         S_QGO: begin
            div_start    = 1'b1;
            div_dividend = prod_ff;
            div_divisor  = period_ff;
            state_in     = S_QDIV;
         end
         S_QDIV: begin
            if (div_done) begin
               if (mode_ff == rgbfx_pkg::MODE_BREATH) begin
                  ratio_in = rgbfx_pkg::BREATH_ROM[div_quo[rgbfx_pkg::BREATH_W-1:0]];
                  sc_in    = '0;
                  state_in = S_SCMUL;
               end else begin
                  hue_in   = hue_q[HUE_W-1:0];
                  state_in = S_HUEL;
               end
            end
         end
         // Scale one byte of the left colour per pass
         S_SCMUL: begin
            mul_a    = PH_W'(sc_byte);
            mul_b    = K_W'(ratio_ff);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            case (sc_ff)
               2'd0: left_grb_in[7:0]  = sc_res;
               2'd1: left_grb_in[15:8] = sc_res;
               default: begin
                  left_grb_in[23:16] = sc_res;
                  right_grb_in       = mirror_ff ? {sc_res, left_grb_ff[15:0]} : '0;
               end
            endcase
            if (sc_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               sc_in    = sc_ff + 2'd1;
               state_in = S_SCMUL;
            end
         end
         // Read the hue table once for each LED
         S_HUEL: begin
            left_grb_in = rgbfx_pkg::HUE_ROM[hue_ff];
            hue_in      = mirror_ff ? hue_ff : hue_opp;
            state_in    = S_HUER;
         end
         S_HUER: begin
            right_grb_in = rgbfx_pkg::HUE_ROM[hue_ff];
            state_in     = S_OUT;
         end
         // Odd half-period count means the dark half
         S_BLINK: begin
            if (div_done) begin
               if (div_quo[0]) begin
                  left_grb_in  = '0;
                  right_grb_in = '0;
               end else begin
                  left_grb_in  = left_rgb_ff;
                  right_grb_in = mirror_ff ? left_rgb_ff : '0;
               end
               state_in = S_OUT;
            end
         end
         // Hand the result to the output register once it is free
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (load_out) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {right_grb_ff[7:0], right_grb_ff[23:16], right_grb_ff[15:8],
                          left_grb_ff[7:0], left_grb_ff[23:16], left_grb_ff[15:8]};
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // Register read-back
   always_comb begin
      case (csr_paddr[4:2])
         rgbfx_pkg::REG_MODE:   csr_prdata = 32'(mode_ff);
         rgbfx_pkg::REG_LEFT:   csr_prdata = 32'(left_rgb_ff);
         rgbfx_pkg::REG_RIGHT:  csr_prdata = 32'(right_rgb_ff);
         rgbfx_pkg::REG_PERIOD: csr_prdata = 32'(period_reg_ff);
         rgbfx_pkg::REG_MIRROR: csr_prdata = 32'(mirror_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // Control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= rgbfx_pkg::MODE_RESET;
         left_rgb_ff   <= '0;
         right_rgb_ff  <= '0;
         period_reg_ff <= rgbfx_pkg::PERIOD_RESET;
         mirror_ff     <= rgbfx_pkg::MIRROR_RESET;
         phase_ff      <= '0;
         sc_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         left_rgb_ff   <= left_rgb_in;
         right_rgb_ff  <= right_rgb_in;
         period_reg_ff <= period_reg_in;
         mirror_ff     <= mirror_in;
         phase_ff      <= phase_in;
         sc_ff         <= sc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      period_ff    <= period_in;
      modulus_ff   <= modulus_in;
      ratio_ff     <= ratio_in;
      hue_ff       <= hue_in;
      left_grb_ff  <= left_grb_in;
      right_grb_ff <= right_grb_in;
      prod_ff      <= prod_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

>>> dv/tb_rgb_led_effect_generator_core.sv
`timescale 1ns / 1ps

module tb_rgb_led_effect_generator_core;
   import rgbfx_pkg::*;

   localparam int TICK_MS       = TICK_MS_DEF;
   localparam int SETTLE_CYCLES = 200;       // well past the longest tick latency
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int REPORT_LIMIT  = 10;
   localparam int REG_COUNT     = 5;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } led_type;

   typedef struct packed {
      led_type right;
      led_type left;
   } pwm_frame_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;    // [0] tick
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;           // [7:0] left_red, [15:8] left_green,
                                     // [23:16] left_blue, [31:24] right_red,
                                     // [39:32] right_green, [47:40] right_blue
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the effect registers and phase counter
   logic [MODE_W-1:0]   cfg_mode;
   logic [RGB_W-1:0]    cfg_left;
   logic [RGB_W-1:0]    cfg_right;
   logic [PERIOD_W-1:0] cfg_period;
   logic                cfg_mirror;
   logic [PHASE_W-1:0]  phase_count;

   pwm_frame_type expected_frames[$];

   int fail_count      = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 16;
   int recv_idle_pct   = 50;
   int rx_hold_request = 0;
   int rx_hold_left    = 0;

   rgb_led_effect_generator_core u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic led_type grb_to_led(logic [RGB_W-1:0] grb);
      led_type led;
      led.red   = grb[15:8];
      led.green = grb[23:16];
      led.blue  = grb[7:0];
      return led;
   endfunction

   // Scale each byte of a color by ratio/255
   function automatic logic [RGB_W-1:0] dim_color(logic [RGB_W-1:0] grb, logic [7:0] ratio);
      logic [RGB_W-1:0] dimmed;
      int unsigned      prod;
      for (int b = 0; b < 3; b++) begin
         prod = int'(grb[b*8 +: 8]) * int'(ratio);
         dimmed[b*8 +: 8] = 8'(prod / 255);
      end
      return dimmed;
   endfunction

   // Advance the phase on a tick and work out the PWM frame, if any
   function automatic void advance_effect(input logic tick, output logic lit,
                                          output pwm_frame_type frame);
      int unsigned     eff;
      int unsigned     modulus;
      int unsigned     pos;
      int unsigned     hue;
      int unsigned     hue_right;
      int unsigned     half;
      logic [RGB_W-1:0] dimmed;
      lit   = 1'b0;
      frame = '0;
      if (!tick)
         return;

      eff = cfg_period;
      if (cfg_mode == MODE_BREATH  && eff < PERIOD_MIN_BREATH)  eff = PERIOD_MIN_BREATH;
      if (cfg_mode == MODE_RAINBOW && eff < PERIOD_MIN_RAINBOW) eff = PERIOD_MIN_RAINBOW;
      if (cfg_mode == MODE_BLINK   && eff < PERIOD_MIN_BLINK)   eff = PERIOD_MIN_BLINK;

      modulus = eff / TICK_MS;
      if (modulus == 0)
         phase_count = '0;
      else
         phase_count = PHASE_W'((int'(phase_count) + 1) % modulus);

      case (cfg_mode)
         MODE_SOLID: begin
            lit         = 1'b1;
            frame.left  = grb_to_led(cfg_left);
            frame.right = grb_to_led(cfg_right);
         end
         MODE_BREATH: begin
            pos         = (int'(phase_count) * BREATH_STEPS * TICK_MS / eff)
                          % BREATH_STEPS;
            dimmed      = dim_color(cfg_left, BREATH_ROM[pos]);
            lit         = 1'b1;
            frame.left  = grb_to_led(dimmed);
            frame.right = cfg_mirror ? grb_to_led(dimmed) : '0;
         end
         MODE_RAINBOW: begin
            hue         = (int'(phase_count) * HUE_STEPS * TICK_MS / eff) % HUE_STEPS;
            hue_right   = cfg_mirror ? hue : (hue + HUE_HALF) % HUE_STEPS;
            lit         = 1'b1;
            frame.left  = grb_to_led(HUE_ROM[hue]);
            frame.right = grb_to_led(HUE_ROM[hue_right]);
         end
         MODE_BLINK: begin
            half = eff / (2 * TICK_MS);
            lit  = 1'b1;
            // dark in the second half of each period
            if (!(half != 0 && ((int'(phase_count) / half) % 2) == 1)) begin
               frame.left  = grb_to_led(cfg_left);
               frame.right = cfg_mirror ? grb_to_led(cfg_left) : '0;
            end
         end
         default: lit = 1'b0;
      endcase
   endfunction

   function automatic void reset_led_model();
      cfg_mode    = MODE_RESET;
      cfg_left    = '0;
      cfg_right   = '0;
      cfg_period  = PERIOD_RESET;
      cfg_mirror  = MIRROR_RESET;
      phase_count = '0;
   endfunction

   // Any write to a known register clears the phase; unknown indexes do nothing
   function automatic void apply_register(logic [REG_W-1:0] index, logic [31:0] value);
      case (index)
         REG_MODE:   cfg_mode   = value[MODE_W-1:0];
         REG_LEFT:   cfg_left   = value[RGB_W-1:0];
         REG_RIGHT:  cfg_right  = value[RGB_W-1:0];
         REG_PERIOD: cfg_period = value[PERIOD_W-1:0];
         REG_MIRROR: cfg_mirror = value[0];
         default:    return;
      endcase
      phase_count = '0;
   endfunction

   function automatic logic [31:0] register_value(logic [REG_W-1:0] index);
      case (index)
         REG_MODE:   return 32'(cfg_mode);
         REG_LEFT:   return 32'(cfg_left);
         REG_RIGHT:  return 32'(cfg_right);
         REG_PERIOD: return 32'(cfg_period);
         REG_MIRROR: return 32'(cfg_mirror);
         default:    return '0;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void note_failure(string msg);
      if (fail_count < REPORT_LIMIT)
         $display("%s", msg);
      fail_count++;
   endfunction

   function automatic void compare_byte(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want)
         note_failure($sformatf("%s: expected %0d, got %0d", field, want, got));
   endfunction

   // Compare each result transfer with the oldest pending frame
   always @(posedge clock) begin
      pwm_frame_type seen;
      pwm_frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = pwm_frame_type'(rsp_tdata);
         if (expected_frames.size() == 0) begin
            note_failure($sformatf("result %h with no tick pending", rsp_tdata));
         end else begin
            want = expected_frames.pop_front();
            compare_byte("left_red",    want.left.red,    seen.left.red);
            compare_byte("left_green",  want.left.green,  seen.left.green);
            compare_byte("left_blue",   want.left.blue,   seen.left.blue);
            compare_byte("right_red",   want.right.red,   seen.right.red);
            compare_byte("right_green", want.right.green, seen.right.green);
            compare_byte("right_blue",  want.right.blue,  seen.right.blue);
         end
      end
   end

   // Result side: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (rx_hold_request != 0) begin
         rx_hold_left    = rx_hold_request;
         rx_hold_request = 0;
      end
      if (rx_hold_left != 0) begin
         rx_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   // Offer one tick; valid stays high after the transfer until the next call
   task automatic send_tick(input logic tick);
      pwm_frame_type frame;
      logic          lit;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, tick};
      do @(posedge clock); while (!req_tready);
      advance_effect(tick, lit, frame);
      if (lit)
         expected_frames.push_back(frame);
   endtask

   // Hold the sender until all results are back and the block has gone quiet
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_W-1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_register(index, value);
   endtask

   task automatic csr_read(input logic [REG_W-1:0] index, output logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
   endtask

   task automatic csr_release();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic verify_registers();
      logic [31:0]      data;
      logic [REG_W-1:0] index;
      for (int i = 0; i < REG_COUNT; i++) begin
         index = REG_W'(i);
         csr_read(index, data);
         if (data !== register_value(index))
            note_failure($sformatf("register %0d: expected %h, got %h",
                                   index, register_value(index), data));
      end
   endtask

   task automatic set_effect(input logic [MODE_W-1:0] mode, input logic [RGB_W-1:0] left,
                             input logic [RGB_W-1:0] right, input logic [PERIOD_W-1:0] period,
                             input logic mirror);
      drain_results();
      csr_write(REG_MODE,   32'(mode));
      csr_write(REG_LEFT,   32'(left));
      csr_write(REG_RIGHT,  32'(right));
      csr_write(REG_PERIOD, 32'(period));
      csr_write(REG_MIRROR, 32'(mirror));
      csr_release();
   endtask

   function automatic logic [RGB_W-1:0] random_color();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return RGB_W'($urandom);
   endfunction

   // Write a random subset of registers, with junk in the unused upper bits
   task automatic pick_random_settings();
      logic [31:0]       word;
      logic [MODE_W-1:0] mode;
      int                r;
      r = $urandom_range(99);
      if (r < 20)      mode = MODE_SOLID;
      else if (r < 45) mode = MODE_BREATH;
      else if (r < 68) mode = MODE_RAINBOW;
      else if (r < 90) mode = MODE_BLINK;
      else if (r < 95) mode = MODE_OFF;
      else             mode = MODE_BLINK + MODE_W'($urandom_range(1, 3));
      word = $urandom;
      word[MODE_W-1:0] = mode;
      csr_write(REG_MODE, word);

      if ($urandom_range(99) < 70) begin
         word = $urandom;
         word[RGB_W-1:0] = random_color();
         csr_write(REG_LEFT, word);
      end
      if ($urandom_range(99) < 50) begin
         word = $urandom;
         word[RGB_W-1:0] = random_color();
         csr_write(REG_RIGHT, word);
      end
      if ($urandom_range(99) < 70) begin
         word = $urandom;
         r = $urandom_range(99);
         // mostly short periods so the phase wraps within a burst
         if (r < 10)      word[PERIOD_W-1:0] = '0;
         else if (r < 15) word[PERIOD_W-1:0] = '1;
         else if (r < 25) word[PERIOD_W-1:0] = PERIOD_W'($urandom_range(1, 60));
         else if (r < 40) word[PERIOD_W-1:0] = PERIOD_W'($urandom_range(150, 2100));
         else             word[PERIOD_W-1:0] = PERIOD_W'($urandom_range(20, 1200));
         csr_write(REG_PERIOD, word);
      end
      if ($urandom_range(99) < 50)
         csr_write(REG_MIRROR, $urandom);
      if ($urandom_range(99) < 10)
         csr_write(REG_MIRROR + REG_W'($urandom_range(1, 3)), $urandom);
      verify_registers();
      csr_release();
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      verify_registers();
      csr_release();
      repeat (2) send_tick(1'b1);
   endtask

   // Solid at the color extremes, then with a period too short for a modulus
   task automatic test_solid_mode();
      set_effect(MODE_SOLID, '1, '0, '0, 1'b1);
      send_tick(1'b1);
      set_effect(MODE_SOLID, '0, '1, PERIOD_W'(TICK_MS - 1), 1'b0);
      send_tick(1'b1);
   endtask

   task automatic test_breathing();
      set_effect(MODE_BREATH, '1, RGB_W'($urandom), '0, 1'b0);
      send_tick(1'b1);
      set_effect(MODE_BREATH, RGB_W'($urandom), '0, '1, 1'b1);
      send_tick(1'b1);
   endtask

   task automatic test_rainbow();
      set_effect(MODE_RAINBOW, '0, '0, '0, 1'b0);
      repeat (2) send_tick(1'b1);
   endtask

   // Off, an unused mode, and zero ticks that must not move the phase
   task automatic test_quiet_inputs();
      set_effect(MODE_OFF, '1, '1, '0, 1'b1);
      send_tick(1'b1);
      set_effect(MODE_BLINK + MODE_W'(3), '1, '1, '0, 1'b1);
      send_tick(1'b1);
      set_effect(MODE_BLINK, RGB_W'($urandom), '1, '0, 1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
   endtask

   // A write past the register list must leave the blink phase running
   task automatic test_unused_register();
      set_effect(MODE_BLINK, '1, '0, '0, 1'b1);
      repeat (4) send_tick(1'b1);
      drain_results();
      csr_write(REG_MIRROR + REG_W'(1), $urandom);
      csr_release();
      repeat (7) send_tick(1'b1);
   endtask

   // Stall the result side long enough to back up the input, then pause
   task automatic test_backpressure();
      set_effect(MODE_SOLID, RGB_W'($urandom), RGB_W'($urandom),
                 PERIOD_W'($urandom_range(0, 2000)), 1'($urandom));
      rx_hold_request = 1500;
      repeat (40) send_tick(1'b1);
      drain_results();
      repeat (20) send_tick(1'b1);
   endtask

   task automatic run_random_traffic(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         drain_results();
         pick_random_settings();
         burst = $urandom_range(10, 120);
         repeat (burst) begin
            if ($urandom_range(99) < 4) begin
               send_tick(1'b0);
            end else begin
               send_tick(1'b1);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset_led_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_solid_mode();
      test_breathing();
      test_rainbow();
      test_quiet_inputs();
      test_unused_register();
      test_backpressure();

      run_random_traffic(450);
      send_idle_pct = 50;
      recv_idle_pct = 16;
      run_random_traffic(450);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_traffic(450);

      drain_results();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/rgbfx_pkg.sv
rtl/core/rgbfx_div.sv
rtl/core/rgb_led_effect_generator_core.sv
dv/tb_rgb_led_effect_generator_core.sv
